// ===== hdl/ftl_pkg.sv =====
`timescale 1ns / 1ps

package ftl_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int FRAME_W    = 10;
    localparam int STATUS_W   = 3;
    localparam int ACT_W      = 2;
    localparam int DUR_W      = 27;
    localparam int TIME_W     = 64;
    localparam int SUM_W      = 37;
    localparam int PLAY_W     = 31;
    localparam int DIV_CNT_W  = $clog2(TIME_W);

    localparam logic [DUR_W-1:0] DAY_MS = 27'd86400000;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic limit;
        logic cmp;
        logic fin;
        logic push;
    } ftl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic limit_hit;
        logic srch_more;
        logic out_free;
    } ftl_sts_t;

endpackage

// ===== hdl/ftl_ram.sv =====
`timescale 1ns / 1ps

module ftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ftl_dp.sv =====
`timescale 1ns / 1ps

module ftl_dp import ftl_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ACT_W-1:0]    action,
    input  logic [DUR_W-1:0]    duration_ms,
    input  logic [TIME_W-1:0]   elapsed_ms,
    input  logic [PLAY_W-1:0]   play_limit,
    input  ftl_cmd_t            cmd,
    output ftl_sts_t            sts,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [FRAME_W-1:0]  frame_index,
    output logic [TIME_W-1:0]   next_change_ms,
    output logic                finished
);

    logic [ACT_W-1:0]     action_reg;
    logic [DUR_W-1:0]     dur_reg;
    logic [TIME_W-1:0]    elapsed_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     total_reg, total_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]     rem_reg;
    logic [TIME_W-1:0]    quot_reg;
    logic [DIV_CNT_W-1:0] bit_cnt_reg;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     hi_reg;
    logic [SUM_W-1:0]     hi_val_reg;
    logic [TIME_W-1:0]    base_reg;
    logic [STATUS_W-1:0]  res_status_reg, out_status_reg;
    logic [FRAME_W-1:0]   res_idx_reg, out_idx_reg;
    logic [TIME_W-1:0]    res_next_reg, out_next_reg;
    logic                 res_fin_reg, out_fin_reg;

    logic [SUM_W-1:0]     sum;
    logic                 append_ok;
    logic [SUM_W:0]       shifted;
    logic [SUM_W+1:0]     diff;
    logic [CNT_W-1:0]     mid;
    logic [CNT_W-1:0]     last_idx;
    logic [CNT_W-1:0]     fin_idx;
    logic [SUM_W-1:0]     rd_data;

    assign sum       = total_reg + {{(SUM_W-DUR_W){1'b0}}, dur_reg};
    assign append_ok = (action_reg == ACT_APPEND) && (dur_reg <= DAY_MS)
                       && (count_reg < CNT_W'(MAX_FRAMES));
    assign shifted   = {rem_reg, quot_reg[TIME_W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, total_reg};
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign last_idx  = count_reg - CNT_W'(1);
    assign fin_idx   = (lo_reg >= count_reg) ? last_idx : lo_reg;

    assign sts.need_div  = (action_reg == ACT_QUERY) && (count_reg > CNT_W'(1))
                           && (total_reg != '0);
    assign sts.div_last  = (bit_cnt_reg == DIV_CNT_W'(TIME_W - 1));
    assign sts.limit_hit = (play_limit != '0)
                           && (quot_reg >= {{(TIME_W-PLAY_W){1'b0}}, play_limit});
    assign sts.srch_more = (lo_reg < hi_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    ftl_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_FRAMES)
    ) u_end_times (
        .clk   (clk),
        .we    (cmd.exec && append_ok),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (sum),
        .raddr (mid[IDX_W-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            if (action_reg == ACT_CLEAR)
            begin
                count_next = '0;
                total_next = '0;
            end
            else if (append_ok)
            begin
                count_next = count_reg + CNT_W'(1);
                total_next = sum;
            end
        end
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= action;
            dur_reg     <= duration_ms;
            elapsed_reg <= elapsed_ms;
        end
        if (cmd.exec)
        begin
            res_status_reg <= ST_OK;
            res_idx_reg    <= '0;
            res_next_reg   <= '0;
            res_fin_reg    <= 1'b0;
            rem_reg        <= '0;
            quot_reg       <= elapsed_reg;
            bit_cnt_reg    <= '0;
            unique case (action_reg)
                ACT_APPEND:
                begin
                    priority if (dur_reg > DAY_MS)
                    begin
                        res_status_reg <= ST_TOO_LONG;
                    end
                    else if (count_reg >= CNT_W'(MAX_FRAMES))
                    begin
                        res_status_reg <= ST_FULL;
                    end
                    else
                    begin
                        res_idx_reg  <= FRAME_W'(count_reg);
                        res_next_reg <= {{(TIME_W-SUM_W){1'b0}}, sum};
                    end
                end
                ACT_QUERY:
                begin
                    priority if (count_reg == '0)
                    begin
                        res_status_reg <= ST_EMPTY;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        res_next_reg <= '1;
                        res_fin_reg  <= 1'b1;
                    end
                    else if (total_reg == '0)
                    begin
                        res_status_reg <= ST_ZERO;
                    end
                    else
                    begin
                        res_status_reg <= ST_OK;
                    end
                end
                default:
                begin
                    res_status_reg <= ST_OK;
                end
            endcase
        end
        if (cmd.div_step)
        begin
            rem_reg     <= diff[SUM_W+1] ? shifted[SUM_W-1:0] : diff[SUM_W-1:0];
            quot_reg    <= {quot_reg[TIME_W-2:0], !diff[SUM_W+1]};
            bit_cnt_reg <= bit_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.limit)
        begin
            base_reg   <= elapsed_reg - {{(TIME_W-SUM_W){1'b0}}, rem_reg};
            lo_reg     <= '0;
            hi_reg     <= count_reg;
            hi_val_reg <= total_reg;
            if (sts.limit_hit)
            begin
                res_idx_reg  <= FRAME_W'(last_idx);
                res_next_reg <= '1;
                res_fin_reg  <= 1'b1;
            end
        end
        if (cmd.cmp)
        begin
            if (rd_data > rem_reg)
            begin
                hi_reg     <= mid;
                hi_val_reg <= rd_data;
            end
            else
            begin
                lo_reg <= mid + CNT_W'(1);
            end
        end
        if (cmd.fin)
        begin
            res_idx_reg  <= FRAME_W'(fin_idx);
            res_next_reg <= base_reg + {{(TIME_W-SUM_W){1'b0}}, hi_val_reg};
        end
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
            out_next_reg   <= res_next_reg;
            out_fin_reg    <= res_fin_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign frame_index    = out_idx_reg;
    assign next_change_ms = out_next_reg;
    assign finished       = out_fin_reg;

`ifndef SYNTHESIS
    a_rem_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < total_reg))
        else $error("divider remainder not below total duration");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |=> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count above table depth");
`endif

endmodule

// ===== hdl/ftl_ctrl.sv =====
`timescale 1ns / 1ps

module ftl_ctrl import ftl_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ftl_sts_t sts,
    output ftl_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_LIMIT = 7'b0001000,
        S_RD    = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_PUSH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_div ? S_DIV : S_PUSH;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = sts.limit_hit ? S_PUSH : S_RD;
            end
            S_RD:
            begin
                if (sts.srch_more)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_RD;
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_EXEC))
        else $error("accepted word not executed next cycle");

    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIMIT && !sts.limit_hit) |=> sts.srch_more)
        else $error("search started with empty range");
`endif

endmodule

// ===== hdl/frame_timeline_lookup.sv =====
`timescale 1ns / 1ps

// Animation timeline table with position lookup. Append words add frame durations to a
// table of cumulative end times, clear words empty it, and query words return the frame
// shown at an elapsed time together with the absolute time at which that frame ends.
// Clear, append, unused action and simple query words go from the execute state straight
// to the push state. A query on a table of two or more frames with a nonzero total runs
// a restoring divider, which produces one quotient bit per cycle, then checks the play
// limit and ends there when it is used up, else runs a binary search in which each probe
// takes a read state and a compare state because the end time table is a memory with a
// registered read port. A result waits while the output register still holds a stalled
// word. The next word is accepted in the idle state that follows the push of the previous
// result into the output register.
// The end time memory has no reset; only appended entries below the frame count are used.
// The play limit register is at byte address 0 of the configuration port.

module frame_timeline_lookup import ftl_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACT_W-1:0]    action,
    input  logic [DUR_W-1:0]    duration_ms,
    input  logic [TIME_W-1:0]   elapsed_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [FRAME_W-1:0]  frame_index,
    output logic [TIME_W-1:0]   next_change_ms,
    output logic                finished
);

    logic [PLAY_W-1:0] play_limit_reg, play_limit_next;
    ftl_cmd_t          cmd;
    ftl_sts_t          sts;

    assign pready = 1'b1;

    always_comb
    begin
        play_limit_next = play_limit_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            play_limit_next = pwdata[PLAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_limit_reg <= '0;
        end
        else
        begin
            play_limit_reg <= play_limit_next;
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {1'b0, play_limit_reg} : 32'd0;

    ftl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (action),
        .duration_ms    (duration_ms),
        .elapsed_ms     (elapsed_ms),
        .play_limit     (play_limit_reg),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .frame_index    (frame_index),
        .next_change_ms (next_change_ms),
        .finished       (finished)
    );

endmodule

// ===== bench/frame_timeline_lookup_test.sv =====
`timescale 1ns / 1ps

module frame_timeline_lookup_test;
    import ftl_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED      = 2'd3;
    localparam logic [2:0]       PLAY_LIMIT_ADDR = 3'd0;
    localparam int               TOTAL_WORDS     = 1850;
    localparam int               CYCLE_LIMIT     = 2000000;
    localparam int               HOLD_CYCLES     = 600;
    localparam logic [TIME_W-1:0] ALL_ONES       = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame_index;
        logic [TIME_W-1:0]   next_change;
        logic                finished;
    } timeline_word_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [ACT_W-1:0]    action;
    logic [DUR_W-1:0]    duration_ms;
    logic [TIME_W-1:0]   elapsed_ms;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_index;
    logic [TIME_W-1:0]   next_change_ms;
    logic                finished;

    logic [TIME_W-1:0]   tl_end [MAX_FRAMES];
    int                  tl_count;
    logic [TIME_W-1:0]   tl_total;
    logic [PLAY_W-1:0]   tl_play;

    timeline_word_t      expected_words[$];
    int                  mismatch_count;
    int                  words_sent;
    int                  words_checked;
    int                  cycle_count;
    int                  hold_requests;
    int                  hold_served;
    int                  hold_left;
    int                  stall_left;
    int                  rx_mode_left;
    bit                  rx_calm;
    int                  tx_calm_left;
    bit                  tx_calm;

    frame_timeline_lookup DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .duration_ms(duration_ms),
        .elapsed_ms(elapsed_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .frame_index(frame_index),
        .next_change_ms(next_change_ms),
        .finished(finished)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic timeline_word_t timeline_step(input logic [ACT_W-1:0] act,
                                                     input logic [DUR_W-1:0] dur,
                                                     input logic [TIME_W-1:0] el);
        timeline_word_t w;
        logic [TIME_W-1:0] loops;
        logic [TIME_W-1:0] pos;
        int lo;
        int hi;
        int mid;
        w = '{default: '0};
        unique case (act)
            ACT_CLEAR:
            begin
                tl_count = 0;
                tl_total = '0;
            end
            ACT_APPEND:
            begin
                if (dur > DAY_MS)
                    w.status = ST_TOO_LONG;
                else if (tl_count >= MAX_FRAMES)
                    w.status = ST_FULL;
                else
                begin
                    tl_total = tl_total + dur;
                    tl_end[tl_count] = tl_total;
                    w.frame_index = FRAME_W'(tl_count);
                    w.next_change = tl_total;
                    tl_count++;
                end
            end
            ACT_QUERY:
            begin
                if (tl_count == 0)
                    w.status = ST_EMPTY;
                else if (tl_count == 1)
                begin
                    w.next_change = ALL_ONES;
                    w.finished = 1'b1;
                end
                else if (tl_total == 0)
                    w.status = ST_ZERO;
                else
                begin
                    loops = el / tl_total;
                    pos = el % tl_total;
                    if (tl_play != 0 && loops >= tl_play)
                    begin
                        w.frame_index = FRAME_W'(tl_count - 1);
                        w.next_change = ALL_ONES;
                        w.finished = 1'b1;
                    end
                    else
                    begin
                        lo = 0;
                        hi = tl_count;
                        while (lo < hi)
                        begin
                            mid = lo + (hi - lo) / 2;
                            if (tl_end[mid] > pos)
                                hi = mid;
                            else
                                lo = mid + 1;
                        end
                        if (lo >= tl_count)
                            lo = tl_count - 1;
                        w.frame_index = FRAME_W'(lo);
                        w.next_change = loops * tl_total + tl_end[lo];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 9)
            return DUR_W'($urandom_range(DAY_MS + 1, 27'h7FF_FFFF));
        if (r < 12)
            return DAY_MS;
        if (r < 55)
            return DUR_W'($urandom_range(1, 100));
        return DUR_W'($urandom_range(0, DAY_MS));
    endfunction

    function automatic logic [TIME_W-1:0] pick_elapsed();
        int r;
        logic [TIME_W-1:0] loops;
        logic [TIME_W-1:0] e;
        r = $urandom_range(0, 99);
        if (tl_total == 0 || r < 15)
            return {$urandom(), $urandom()};
        if (tl_play != 0 && tl_play < 8)
            loops = TIME_W'($urandom_range(0, tl_play + 1));
        else
            loops = TIME_W'($urandom_range(0, 6));
        if (r < 20)
            return ALL_ONES - $urandom_range(0, 2000);
        if (r < 50)
            return loops * tl_total + ({$urandom(), $urandom()} % tl_total);
        if (r < 80)
        begin
            e = loops * tl_total + tl_end[$urandom_range(0, tl_count - 1)];
            return $urandom_range(0, 1) ? e : e - 1;
        end
        return $urandom_range(0, 3) * tl_total + $urandom_range(0, 15);
    endfunction

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [DUR_W-1:0] dur,
                             input logic [TIME_W-1:0] el);
        int r;
        int gap;
        if (tx_calm_left == 0)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            tx_calm_left = $urandom_range(20, 100);
        end
        tx_calm_left--;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        duration_ms <= dur;
        elapsed_ms <= el;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_words.insert(expected_words.size(), timeline_step(act, dur, el));
        words_sent++;
    endtask

    task automatic send_noise();
        send_word(ACT_W'($urandom_range(0, 3)), DUR_W'($urandom()), {$urandom(), $urandom()});
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
    endtask

    task automatic write_play_limit(input logic [31:0] value);
        wait_drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PLAY_LIMIT_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tl_play = value[PLAY_W-1:0];
    endtask

    task automatic test_directed_cases();
        write_play_limit(32'd0);
        send_word(ACT_QUERY, '0, ALL_ONES);
        send_word(ACT_UNUSED, '1, ALL_ONES);
        send_word(ACT_APPEND, DAY_MS + 1, '0);
        send_word(ACT_APPEND, '1, '0);
        send_word(ACT_APPEND, '0, '0);
        send_word(ACT_QUERY, '0, 64'd12345);
        send_word(ACT_APPEND, '0, '0);
        send_word(ACT_QUERY, '0, 64'd7);
        send_word(ACT_CLEAR, '1, ALL_ONES);
        send_word(ACT_APPEND, DAY_MS, '0);
        send_word(ACT_APPEND, 27'd1, '0);
        send_word(ACT_APPEND, 27'd5, '0);
        send_word(ACT_QUERY, '0, '0);
        send_word(ACT_QUERY, '0, TIME_W'(DAY_MS));
        send_word(ACT_QUERY, '0, TIME_W'(DAY_MS) + 1);
        send_word(ACT_QUERY, '0, tl_total);
        send_word(ACT_QUERY, '0, ALL_ONES);
        write_play_limit(32'd1);
        send_word(ACT_QUERY, '0, tl_total - 1);
        send_word(ACT_QUERY, '0, tl_total);
        write_play_limit(32'hFFFF_FFFF);
        send_word(ACT_QUERY, '0, ALL_ONES);
        send_word(ACT_QUERY, '0, 64'h8000_0000_0000_0000);
        write_play_limit(32'd0);
        send_word(ACT_CLEAR, '0, '0);
        repeat (3) send_word(ACT_APPEND, 27'd1, '0);
        send_word(ACT_QUERY, '0, ALL_ONES);
    endtask

    task automatic test_full_table();
        send_word(ACT_CLEAR, '0, '0);
        while (tl_count < MAX_FRAMES)
            send_word(ACT_APPEND, pick_duration(), {$urandom(), $urandom()});
        send_word(ACT_APPEND, '0, '0);
        send_word(ACT_APPEND, DAY_MS, '0);
        send_word(ACT_APPEND, DAY_MS + 1, '0);
        repeat (24) send_word(ACT_QUERY, DUR_W'($urandom()), pick_elapsed());
    endtask

    task automatic test_backpressure();
        wait_drain();
        hold_requests++;
        tx_calm = 1'b1;
        tx_calm_left = 40;
        send_word(ACT_CLEAR, '0, '0);
        repeat (8) send_word(ACT_APPEND, pick_duration(), '0);
        repeat (8) send_word(ACT_QUERY, '0, pick_elapsed());
        wait_drain();
    endtask

    task automatic test_random_timelines();
        int frames;
        int queries;
        int r;
        logic [31:0] limit;
        while (words_sent < TOTAL_WORDS)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                r = $urandom_range(0, 9);
                unique case (r)
                    0, 9: limit = 32'd0;
                    5: limit = 32'h7FFF_FFFF;
                    6: limit = 32'hFFFF_FFFF;
                    7: limit = $urandom();
                    8: limit = $urandom_range(5, 40);
                    default: limit = $urandom_range(1, 4);
                endcase
                write_play_limit(limit);
            end
            if ($urandom_range(0, 5) != 0)
                send_word(ACT_CLEAR, DUR_W'($urandom()), {$urandom(), $urandom()});
            frames = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            repeat (frames)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_noise();
                send_word(ACT_APPEND, pick_duration(), {$urandom(), $urandom()});
            end
            queries = $urandom_range(1, 10);
            repeat (queries)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_noise();
                send_word(ACT_QUERY, DUR_W'($urandom()), pick_elapsed());
            end
        end
    endtask

    // The receiver stalls in random bursts, with calm stretches and requested long holds.
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
                rx_mode_left = $urandom_range(50, 300);
            end
            rx_mode_left--;
            if (rx_calm)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: status %0d frame %0d next %h finished %0d",
                             status, frame_index, next_change_ms, finished);
            end
            else
            begin
                if (expected_words[0].status !== status ||
                    expected_words[0].frame_index !== frame_index ||
                    expected_words[0].next_change !== next_change_ms ||
                    expected_words[0].finished !== finished)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result word %0d: expected status %0d frame %0d next %h ",
                                  "finished %0d, got status %0d frame %0d next %h finished %0d"},
                                 words_checked, expected_words[0].status,
                                 expected_words[0].frame_index, expected_words[0].next_change,
                                 expected_words[0].finished, status, frame_index,
                                 next_change_ms, finished);
                end
                void'(expected_words.pop_front());
            end
            words_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("frame_timeline_lookup_test: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        action <= '0;
        duration_ms <= '0;
        elapsed_ms <= '0;
        out_stall <= 1'b0;
        tl_count = 0;
        tl_total = '0;
        tl_play = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_table();
        test_backpressure();
        test_random_timelines();
        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("frame_timeline_lookup_test: clean");
        else
            $display("frame_timeline_lookup_test: errors");
        $finish;
    end

endmodule
